@@ sv/apg_pkg.sv @@
// Shared types, constants and the CORDIC angle table of the arc point generator.
`timescale 1ns / 1ps
package apg_pkg;

   localparam int INDEX_W    = 6;
   localparam int RADIUS_W   = 16;
   localparam int ANGLE_W    = 16;
   localparam int COUNT_W    = 7;
   localparam int COORD_W    = 17;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam int MAX_POINTS    = 64;
   localparam int CORDIC_STAGES = 16;
   localparam int DEN_W      = COUNT_W;
   localparam int DIFF_W     = ANGLE_W + 1;
   localparam int MAG_W      = ANGLE_W;
   localparam int DIVIDEND_W = INDEX_W + MAG_W;
   localparam int DIV_STEPS  = DIVIDEND_W;
   localparam int SUM_W      = ANGLE_W + 2;
   localparam int ANG_FRAC   = 17;
   localparam int TURN_W     = SUM_W + ANG_FRAC;
   localparam int WRAP_STEPS = 4;
   localparam int VEC_W      = 32;
   localparam int GAIN_W     = 30;
   localparam int GAIN_SHIFT = 16;
   localparam int OUT_SHIFT  = 14;
   localparam int OUT_LIMIT  = 65535;

   localparam logic [RADIUS_W-1:0]        RADIUS_RESET = 16'd256;
   localparam logic signed [ANGLE_W-1:0]  START_RESET  = 16'sd0;
   localparam logic signed [ANGLE_W-1:0]  END_RESET    = 16'sd6434;
   localparam logic [COUNT_W-1:0]         COUNT_RESET  = 7'd33;
   localparam logic signed [ANGLE_W-1:0]  FULL_TURN    = 16'sd25736;
   localparam logic [GAIN_W-1:0]          CORDIC_GAIN  = 30'd652032874;

   localparam logic signed [TURN_W-1:0] TURN_PI     = 35'sd1686629713;
   localparam logic signed [TURN_W-1:0] TURN_TWO_PI = 35'sd3373259426;
   localparam logic signed [VEC_W-1:0]  VEC_PI      = 32'sd1686629713;
   localparam logic signed [VEC_W-1:0]  VEC_HALF_PI = 32'sd843314857;

   typedef logic signed [VEC_W-1:0] vec_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_RADIUS = 2'd0,
      CSR_START  = 2'd1,
      CSR_END    = 2'd2,
      CSR_COUNT  = 2'd3
   } csr_reg_type;

   typedef struct packed {
      logic                    valid;
      logic [DEN_W-1:0]        rem;
      logic [DIVIDEND_W-1:0]   work;
      logic [DEN_W-1:0]        den;
      logic                    neg;
      logic signed [ANGLE_W-1:0] start;
   } div_stage_type;

   typedef struct packed {
      logic                     valid;
      logic signed [TURN_W-1:0] z;
   } wrap_stage_type;

   typedef struct packed {
      logic    valid;
      vec_type x;
      vec_type y;
      vec_type z;
      logic    neg;
   } cordic_stage_type;

   function automatic vec_type atan_step(input int unsigned k);
      vec_type a;
      unique case (k)
         0: a = 32'sd421657428;
         1: a = 32'sd248918915;
         2: a = 32'sd131521918;
         3: a = 32'sd66762579;
         4: a = 32'sd33510843;
         5: a = 32'sd16771758;
         6: a = 32'sd8387925;
         7: a = 32'sd4194219;
         8: a = 32'sd2097141;
         9: a = 32'sd1048575;
         default: begin
            if (k < 29) a = VEC_W'(64'sd1 <<< (29 - k));
            else        a = '0;
         end
      endcase
      return a;
   endfunction

endpackage

@@ sv/apg_if.sv @@
// Request, response and register write channels of the arc point generator.
`timescale 1ns / 1ps
interface apg_req_if;
   logic                        valid;
   logic                        ready;
   logic [apg_pkg::INDEX_W-1:0] point_index;
   modport source (output valid, output point_index, input ready);
   modport sink   (input valid, input point_index, output ready);
endinterface

interface apg_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [apg_pkg::COORD_W-1:0] x_coord;
   logic signed [apg_pkg::COORD_W-1:0] y_coord;
   modport source (output valid, output x_coord, output y_coord, input ready);
   modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface apg_csr_if;
   logic                           valid;
   logic                           ready;
   logic [apg_pkg::CSR_ADDR_W-1:0] index;
   logic [apg_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/apg_div_cell.sv @@
// One restoring division step: one quotient bit of the angle step per cell.
`timescale 1ns / 1ps
module apg_div_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  apg_pkg::div_stage_type up_stage,
   output apg_pkg::div_stage_type down_stage
);
   import apg_pkg::*;

   div_stage_type    stage_ff;
   div_stage_type    stage_in;
   logic [DEN_W:0]   trial;
   logic             fits;

   always_comb begin
      trial    = {up_stage.rem, up_stage.work[DIVIDEND_W-1]};
      fits     = trial >= {1'b0, up_stage.den};
      stage_in = up_stage;
      if (fits) stage_in.rem = DEN_W'(trial - {1'b0, up_stage.den});
      else      stage_in.rem = trial[DEN_W-1:0];
      stage_in.work = {up_stage.work[DIVIDEND_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign down_stage = stage_ff;

endmodule

@@ sv/apg_wrap_cell.sv @@
// One whole-turn reduction step of the point angle towards (-pi, pi].
`timescale 1ns / 1ps
module apg_wrap_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  apg_pkg::wrap_stage_type up_stage,
   output apg_pkg::wrap_stage_type down_stage
);
   import apg_pkg::*;

   wrap_stage_type stage_ff;
   wrap_stage_type stage_in;

   always_comb begin
      stage_in = up_stage;
      priority if (up_stage.z > TURN_PI) begin
         stage_in.z = up_stage.z - TURN_TWO_PI;
      end else if (up_stage.z <= -TURN_PI) begin
         stage_in.z = up_stage.z + TURN_TWO_PI;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign down_stage = stage_ff;

endmodule

@@ sv/apg_cordic_cell.sv @@
// One rotation-mode CORDIC iteration with its fixed shift and angle.
`timescale 1ns / 1ps
module apg_cordic_cell #(
   parameter int unsigned STAGE = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  apg_pkg::cordic_stage_type up_stage,
   output apg_pkg::cordic_stage_type down_stage
);
   import apg_pkg::*;

   localparam vec_type ATAN = atan_step(STAGE);

   cordic_stage_type stage_ff;
   cordic_stage_type stage_in;
   vec_type          dx;
   vec_type          dy;

   always_comb begin
      dx       = up_stage.y >>> STAGE;
      dy       = up_stage.x >>> STAGE;
      stage_in = up_stage;
      if (!up_stage.z[VEC_W-1]) begin
         stage_in.x = up_stage.x - dx;
         stage_in.y = up_stage.y + dy;
         stage_in.z = up_stage.z - ATAN;
      end else begin
         stage_in.x = up_stage.x + dx;
         stage_in.y = up_stage.y - dy;
         stage_in.z = up_stage.z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign down_stage = stage_ff;

endmodule

@@ sv/arc_point_generator.sv @@
// Top level of the arc point generator: registers, pipeline of cells and result stage.
`timescale 1ns / 1ps
// Takes one point index per cycle while no result is held at the output and
// returns the x and y of that point on the configured arc, one result per
// request, in request order. The pipeline is made of an input stage with the
// index multiply, one cell per quotient bit of the 22-bit angle step division,
// an angle stage, four whole-turn reduction cells, a quadrant fold with the
// radius scaling, one cell per CORDIC iteration and the result register. All
// stages move together; while a result waits at the output with rsp.ready low
// the whole pipeline holds and req.ready is low. Register writes are taken at once
// (csr.ready is always high) and must only be made while no request is in flight.
module arc_point_generator #(
   parameter int CORDIC_STAGES = apg_pkg::CORDIC_STAGES
) (
   input logic       clock,
   input logic       reset,
   apg_req_if.sink   req,
   apg_rsp_if.source rsp,
   apg_csr_if.sink   csr
);
   import apg_pkg::*;

   logic [RADIUS_W-1:0]        radius_ff, radius_in;
   logic signed [ANGLE_W-1:0]  start_ff, start_in;
   logic signed [ANGLE_W-1:0]  end_ff, end_in;
   logic [COUNT_W-1:0]         count_ff, count_in;

   logic advance;

   div_stage_type    div_pipe    [0:DIV_STEPS];
   wrap_stage_type   wrap_pipe   [0:WRAP_STEPS];
   cordic_stage_type cordic_pipe [0:CORDIC_STAGES];

   div_stage_type    front_in;
   div_stage_type    front_ff;
   wrap_stage_type   angle_in;
   wrap_stage_type   angle_ff;
   cordic_stage_type entry_in;
   cordic_stage_type entry_ff;

   logic signed [ANGLE_W-1:0]     s_ang, e_ang;
   logic [COUNT_W-1:0]            n_pts;
   logic [DEN_W-1:0]              den;
   logic [INDEX_W-1:0]            idx;
   logic signed [DIFF_W-1:0]      diff;
   logic [DIFF_W-1:0]             diff_mag;
   logic [DIVIDEND_W-1:0]         product;

   logic [SUM_W-1:0]              q_bits;
   logic signed [SUM_W-1:0]       q_signed;
   logic signed [SUM_W-1:0]       sum;

   vec_type                       z_fold;
   logic [RADIUS_W+GAIN_W-1:0]    scaled;

   logic                          out_valid_ff;
   logic signed [COORD_W-1:0]     x_coord_ff, x_coord_in;
   logic signed [COORD_W-1:0]     y_coord_ff, y_coord_in;

   function automatic logic signed [COORD_W-1:0] round_coord(input vec_type v,
                                                             input logic neg);
      logic signed [VEC_W:0] biased;
      logic signed [VEC_W:0] r;
      biased = (VEC_W+1)'(v) + (VEC_W+1)'(1 << (OUT_SHIFT - 1));
      r      = biased >>> OUT_SHIFT;
      if (neg) r = -r;
      if (r > (VEC_W+1)'(OUT_LIMIT))  r = (VEC_W+1)'(OUT_LIMIT);
      if (r < -(VEC_W+1)'(OUT_LIMIT)) r = -(VEC_W+1)'(OUT_LIMIT);
      return COORD_W'(r);
   endfunction

   // configuration registers
   always_comb begin
      radius_in = radius_ff;
      start_in  = start_ff;
      end_in    = end_ff;
      count_in  = count_ff;
      if (csr.valid) begin
         unique case (csr_reg_type'(csr.index))
            CSR_RADIUS: radius_in = csr.data[RADIUS_W-1:0];
            CSR_START:  start_in  = $signed(csr.data[ANGLE_W-1:0]);
            CSR_END:    end_in    = $signed(csr.data[ANGLE_W-1:0]);
            CSR_COUNT:  count_in  = csr.data[COUNT_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
         start_ff  <= START_RESET;
         end_ff    <= END_RESET;
         count_ff  <= COUNT_RESET;
      end else begin
         radius_ff <= radius_in;
         start_ff  <= start_in;
         end_ff    <= end_in;
         count_ff  <= count_in;
      end
   end

   assign csr.ready = 1'b1;

   // hold every stage while a result waits
   assign advance   = !out_valid_ff || rsp.ready;
   assign req.ready = advance;

   // input stage: clamp, angle span and index multiply
   always_comb begin
      s_ang = start_ff;
      e_ang = end_ff;
      if (s_ang == e_ang) begin
         s_ang = '0;
         e_ang = FULL_TURN;
      end
      n_pts = count_ff;
      if (n_pts < COUNT_W'(2)) n_pts = COUNT_W'(2);
      if (int'(n_pts) > MAX_POINTS) n_pts = COUNT_W'(MAX_POINTS);
      den = DEN_W'(n_pts - COUNT_W'(1));
      idx = req.point_index;
      if (DEN_W'(idx) > den) idx = den[INDEX_W-1:0];
      diff     = DIFF_W'(e_ang) - DIFF_W'(s_ang);
      diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
      product  = DIVIDEND_W'(idx) * DIVIDEND_W'(diff_mag[MAG_W-1:0]);
      front_in.valid = req.valid;
      front_in.rem   = '0;
      front_in.work  = product + DIVIDEND_W'(den >> 1);
      front_in.den   = den;
      front_in.neg   = diff[DIFF_W-1];
      front_in.start = s_ang;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff.valid <= 1'b0;
      end else if (advance) begin
         front_ff <= front_in;
      end
   end

   assign div_pipe[0] = front_ff;

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      apg_div_cell u_div_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .up_stage   (div_pipe[k]),
         .down_stage (div_pipe[k+1])
      );
   end

   // angle stage: start plus signed step, scaled to CORDIC angle units
   always_comb begin
      q_bits   = div_pipe[DIV_STEPS].work[SUM_W-1:0];
      q_signed = div_pipe[DIV_STEPS].neg ? -$signed(q_bits) : $signed(q_bits);
      sum      = SUM_W'(div_pipe[DIV_STEPS].start) + q_signed;
      angle_in.valid = div_pipe[DIV_STEPS].valid;
      angle_in.z     = $signed({sum, {ANG_FRAC{1'b0}}});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff.valid <= 1'b0;
      end else if (advance) begin
         angle_ff <= angle_in;
      end
   end

   assign wrap_pipe[0] = angle_ff;

   for (genvar k = 0; k < WRAP_STEPS; k++) begin : g_wrap
      apg_wrap_cell u_wrap_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .up_stage   (wrap_pipe[k]),
         .down_stage (wrap_pipe[k+1])
      );
   end

   // entry stage: fold into [-pi/2, pi/2], scale radius by the CORDIC gain
   always_comb begin
      z_fold = wrap_pipe[WRAP_STEPS].z[VEC_W-1:0];
      entry_in.valid = wrap_pipe[WRAP_STEPS].valid;
      entry_in.neg   = 1'b0;
      entry_in.z     = z_fold;
      priority if (z_fold > VEC_HALF_PI) begin
         entry_in.z   = z_fold - VEC_PI;
         entry_in.neg = 1'b1;
      end else if (z_fold < -VEC_HALF_PI) begin
         entry_in.z   = z_fold + VEC_PI;
         entry_in.neg = 1'b1;
      end
      scaled     = (RADIUS_W+GAIN_W)'(radius_ff) * (RADIUS_W+GAIN_W)'(CORDIC_GAIN);
      entry_in.x = VEC_W'(scaled[RADIUS_W+GAIN_W-1:GAIN_SHIFT]);
      entry_in.y = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else if (advance) begin
         entry_ff <= entry_in;
      end
   end

   assign cordic_pipe[0] = entry_ff;

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
      apg_cordic_cell #(
         .STAGE (k)
      ) u_cordic_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .up_stage   (cordic_pipe[k]),
         .down_stage (cordic_pipe[k+1])
      );
   end

   // result stage: round, negate when folded, saturate
   always_comb begin
      x_coord_in = round_coord(cordic_pipe[CORDIC_STAGES].x, cordic_pipe[CORDIC_STAGES].neg);
      y_coord_in = round_coord(cordic_pipe[CORDIC_STAGES].y, cordic_pipe[CORDIC_STAGES].neg);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= cordic_pipe[CORDIC_STAGES].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_coord_ff <= x_coord_in;
         y_coord_ff <= y_coord_in;
      end
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.x_coord = x_coord_ff;
   assign rsp.y_coord = y_coord_ff;

endmodule
